>>> hdl/bitmap_page_frame_allocator_macros.svh
// ---------------------------------------------------------------------------
// Bitmap page frame allocator assertion macros
// Shared concurrent assertion forms used by the allocator RTL.
// ---------------------------------------------------------------------------
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPFA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bpfa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bitmap page frame allocator package
// Field widths, operation and status codes, and register indexes.
// ---------------------------------------------------------------------------
package bpfa_pkg;

  localparam int OPCODE_W    = 2;
  localparam int ADDR_IN_W   = 32;
  localparam int ADDR_W      = 27;
  localparam int STATUS_W    = 2;
  localparam int CFG_DATA_W  = 18;
  localparam int REG_IDX_W   = 2;
  localparam int MEM_KB_W    = 18;
  localparam int INIT_FREE_W = 16;
  localparam int RSV_W       = 15;
  localparam int FRAME_SHIFT = 12;
  localparam int FRAME_CMP_W = 21;

  localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_INIT  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_NOP   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_MEM = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_MEM_SIZE_KB = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INIT_FREE   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RSV_FIRST   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_RSV_LAST    = 2'd3;

  localparam logic [MEM_KB_W-1:0]    MEM_KB_RESET    = 18'd131072;
  localparam logic [INIT_FREE_W-1:0] INIT_FREE_RESET = 16'd4096;
  localparam logic [RSV_W-1:0]       RSV_FIRST_RESET = 15'd0;
  localparam logic [RSV_W-1:0]       RSV_LAST_RESET  = 15'd0;

endpackage

>>> hdl/bpfa_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bitmap page frame allocator channels
// Request and response channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
interface bpfa_req_if import bpfa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [ADDR_IN_W-1:0] frame_address;

  modport source (output valid, output opcode, output frame_address, input ready);
  modport sink (input valid, input opcode, input frame_address, output ready);
endinterface

interface bpfa_rsp_if import bpfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   result_address;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output result_address, output status, input ready);
  modport sink (input valid, input result_address, input status, output ready);
endinterface

>>> hdl/bpfa_word_scan.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bitmap page frame allocator word scan
// Finds the lowest free frame below the frame count within one map word.
// ---------------------------------------------------------------------------
module bpfa_word_scan import bpfa_pkg::*; #(
  parameter int WORD_BITS = 32,
  localparam int BIT_W = $clog2(WORD_BITS)
) (
  input  logic [WORD_BITS-1:0]   word_i,
  input  logic [FRAME_CMP_W-1:0] base_i,
  input  logic [FRAME_CMP_W-1:0] total_i,
  output logic                   found_o,
  output logic [BIT_W-1:0]       bit_o,
  output logic [WORD_BITS-1:0]   onehot_o
);

  logic [WORD_BITS-1:0] avail;
  logic [WORD_BITS-1:0] lowest;
  logic [BIT_W-1:0]     idx;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      avail[b] = !word_i[b] && ((base_i + FRAME_CMP_W'(b)) < total_i);
    end
  end

  assign lowest = avail & (~avail + WORD_BITS'(1));

  always_comb begin
    idx = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (lowest[b]) begin
        idx = idx | BIT_W'(b);
      end
    end
  end

  assign found_o  = |avail;
  assign bit_o    = idx;
  assign onehot_o = lowest;

endmodule

>>> hdl/bitmap_page_frame_allocator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bitmap page frame allocator
// Keeps one bit per 4 KiB frame in a word memory and serves alloc, free and
// init items on a request channel with one response item each.
// ---------------------------------------------------------------------------
// Items arrive on req_i and each produces one response item on rsp_o. The
// block works on one item at a time and the map memory sets the pace: the
// scan reads one map word per cycle.
// A no-op or an out-of-range free goes straight to the response; an in-range
// free reads its map word and writes it back; an alloc scans words from the
// lowest word that may hold a free frame (it scans none when that word
// already lies past the frame count); an init writes every map word.
// A new item is accepted once the previous one has been handed to the
// response register, so the next item can start while a response still
// waits. When the receiver stalls with a response pending, a finished item
// waits until the response register drains.
// After reset the block fills every map word with ones, marking every frame
// used; it accepts no item during that pass, while register writes are
// taken at any time. WORD_BITS must be a power of two.
// ---------------------------------------------------------------------------
module bitmap_page_frame_allocator import bpfa_pkg::*; #(
  parameter int MAX_FRAMES = 32768,
  parameter int WORD_BITS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bpfa_req_if.sink              req_i,
  bpfa_rsp_if.source            rsp_o
);

  `include "bitmap_page_frame_allocator_macros.svh"

  localparam int S         = $clog2(WORD_BITS);
  localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int FIW       = AW + S;
  localparam int CW        = FRAME_CMP_W;
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_FREE  = 3'd3;
  localparam logic [2:0] ST_INIT  = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [AW-1:0]          cur_q, cur_d;
  logic [AW-1:0]          hint_q, hint_d;
  logic [S-1:0]           bit_q, bit_d;
  logic [ADDR_W-1:0]      res_addr_q, res_addr_d;
  logic [STATUS_W-1:0]    res_status_q, res_status_d;
  logic                   rsp_valid_q;
  logic [ADDR_W-1:0]      rsp_addr_q;
  logic [STATUS_W-1:0]    rsp_status_q;

  logic [MEM_KB_W-1:0]    mem_kb_q;
  logic [INIT_FREE_W-1:0] init_free_q;
  logic [RSV_W-1:0]       rsv_first_q;
  logic [RSV_W-1:0]       rsv_last_q;

  logic [WORD_BITS-1:0]   map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0]   rdata_q;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [AW-1:0]          mem_raddr;
  logic [WORD_BITS-1:0]   mem_wdata;

  logic [CW-1:0]          total;
  logic [CW-1:0]          last_word;
  logic [CW-1:0]          lim;
  logic [CW-1:0]          free_frame;
  logic [CW-1:0]          cur_base;
  logic                   rsv_en;
  logic [WORD_BITS-1:0]   init_word;
  logic                   scan_found;
  logic [S-1:0]           scan_bit;
  logic [WORD_BITS-1:0]   scan_onehot;
  logic [FIW-1:0]         alloc_frame;
  logic [31:0]            alloc_ext;
  logic                   out_free;
  logic                   req_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_kb_q    <= MEM_KB_RESET;
      init_free_q <= INIT_FREE_RESET;
      rsv_first_q <= RSV_FIRST_RESET;
      rsv_last_q  <= RSV_LAST_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MEM_SIZE_KB: mem_kb_q    <= cfg_data_i[MEM_KB_W-1:0];
        REG_INIT_FREE:   init_free_q <= cfg_data_i[INIT_FREE_W-1:0];
        REG_RSV_FIRST:   rsv_first_q <= cfg_data_i[RSV_W-1:0];
        REG_RSV_LAST:    rsv_last_q  <= cfg_data_i[RSV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= map_mem[mem_raddr];
  end

  always_comb begin
    if (CW'(mem_kb_q[MEM_KB_W-1:2]) > CW'(MAX_FRAMES)) begin
      total = CW'(MAX_FRAMES);
    end else begin
      total = CW'(mem_kb_q[MEM_KB_W-1:2]);
    end
  end

  assign last_word  = (total - CW'(1)) >> S;
  assign lim        = (CW'(init_free_q) < total) ? CW'(init_free_q) : total;
  assign free_frame = CW'(req_i.frame_address[ADDR_IN_W-1:FRAME_SHIFT]);
  assign cur_base   = CW'({cur_q, {S{1'b0}}});
  assign rsv_en     = (rsv_first_q <= rsv_last_q);

  always_comb begin
    logic [CW-1:0] frm;
    frm = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      frm = cur_base + CW'(b);
      init_word[b] = !((frm < lim) && (frm != '0) &&
                       !(rsv_en && (frm >= CW'(rsv_first_q)) && (frm <= CW'(rsv_last_q))));
    end
  end

  bpfa_word_scan #(
    .WORD_BITS (WORD_BITS)
  ) u_scan (
    .word_i   (rdata_q),
    .base_i   (cur_base),
    .total_i  (total),
    .found_o  (scan_found),
    .bit_o    (scan_bit),
    .onehot_o (scan_onehot)
  );

  assign alloc_frame = {cur_q, scan_bit};
  assign alloc_ext   = 32'(alloc_frame);
  assign out_free    = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    hint_d       = hint_q;
    bit_d        = bit_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_waddr    = cur_q;
    mem_wdata    = '1;
    mem_raddr    = cur_q;
    req_ready    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (cur_q == LAST_WORD) begin
          cur_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cur_d = cur_q + AW'(1);
        end
      end
      ST_IDLE: begin
        req_ready    = 1'b1;
        mem_raddr    = hint_q;
        res_addr_d   = '0;
        res_status_d = STATUS_OK;
        if (req_i.valid) begin
          case (req_i.opcode)
            OP_ALLOC: begin
              if ((total == '0) || (CW'(hint_q) > last_word)) begin
                res_status_d = STATUS_NO_MEM;
                state_d      = ST_RESP;
              end else begin
                cur_d   = hint_q;
                state_d = ST_SCAN;
              end
            end
            OP_FREE: begin
              if (free_frame < total) begin
                mem_raddr = free_frame[FIW-1:S];
                cur_d     = free_frame[FIW-1:S];
                bit_d     = free_frame[S-1:0];
                state_d   = ST_FREE;
              end else begin
                res_status_d = STATUS_RANGE;
                state_d      = ST_RESP;
              end
            end
            OP_INIT: begin
              cur_d   = '0;
              hint_d  = '0;
              state_d = ST_INIT;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_SCAN: begin
        mem_raddr = cur_q + AW'(1);
        if (scan_found) begin
          mem_we       = 1'b1;
          mem_wdata    = rdata_q | scan_onehot;
          hint_d       = cur_q;
          res_addr_d   = {alloc_ext[ADDR_W-FRAME_SHIFT-1:0], {FRAME_SHIFT{1'b0}}};
          res_status_d = STATUS_OK;
          state_d      = ST_RESP;
        end else if (CW'(cur_q) == last_word) begin
          res_status_d = STATUS_NO_MEM;
          state_d      = ST_RESP;
        end else begin
          cur_d = cur_q + AW'(1);
        end
      end
      ST_FREE: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q & ~(WORD_BITS'(1) << bit_q);
        if (cur_q < hint_q) begin
          hint_d = cur_q;
        end
        state_d = ST_RESP;
      end
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = init_word;
        if (cur_q == LAST_WORD) begin
          cur_d   = '0;
          state_d = ST_RESP;
        end else begin
          cur_d = cur_q + AW'(1);
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cur_q       <= '0;
      hint_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      hint_q  <= hint_d;
      if ((state_q == ST_RESP) && out_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q        <= bit_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    if ((state_q == ST_RESP) && out_free) begin
      rsp_addr_q   <= res_addr_q;
      rsp_status_q <= res_status_q;
    end
  end

  assign req_i.ready          = req_ready;
  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.result_address = rsp_addr_q;
  assign rsp_o.status         = rsp_status_q;

  `BPFA_ASSERT_SAME(a_no_accept_while_clearing, clk_i, rst_ni,
                    state_q == ST_CLEAR, !req_i.ready, "item accepted during map clearing")
  `BPFA_ASSERT_SAME(a_map_write_states, clk_i, rst_ni, mem_we,
                    (state_q == ST_CLEAR) || (state_q == ST_SCAN) ||
                    (state_q == ST_FREE) || (state_q == ST_INIT),
                    "map written outside a working state")
  `BPFA_ASSERT_SAME(a_zero_addr_on_error, clk_i, rst_ni,
                    rsp_o.valid && (rsp_o.status != STATUS_OK),
                    rsp_o.result_address == '0, "nonzero address with error status")
  `BPFA_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni,
                    (state_q == ST_RESP) && !rsp_valid_q, rsp_valid_q,
                    "finished item not loaded into response register")

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bitmap page frame allocator testbench
// Drives alloc, free, init and no-op items through the request channel with
// random gaps and back-pressure. It checks every response item against a
// local copy of the frame map that is updated as each item is accepted.
// Directed items cover the field extremes and the corner cases. Random
// phases follow, each with its own register settings.
// ---------------------------------------------------------------------------
module testbench;
  import bpfa_pkg::*;

  localparam int N_FRAMES  = 32768;
  localparam int WORD_BITS = 32;
  localparam int N_WORDS   = N_FRAMES / WORD_BITS;
  localparam int N_PHASES  = 12;
  localparam int PHASE_LEN = 112;

  typedef struct packed {
    logic [OPCODE_W-1:0]  opcode;
    logic [ADDR_IN_W-1:0] frame_address;
  } frame_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   result_address;
    logic [STATUS_W-1:0] status;
  } frame_rsp_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [REG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bpfa_req_if req_if ();
  bpfa_rsp_if rsp_if ();

  bitmap_page_frame_allocator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if.sink),
    .rsp_o      (rsp_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Local copy of the frame map and the registers.
  logic [WORD_BITS-1:0]   frame_words [N_WORDS];
  logic [MEM_KB_W-1:0]    mem_kb    = MEM_KB_RESET;
  logic [INIT_FREE_W-1:0] init_free = INIT_FREE_RESET;
  logic [RSV_W-1:0]       rsv_lo    = RSV_FIRST_RESET;
  logic [RSV_W-1:0]       rsv_hi    = RSV_LAST_RESET;

  frame_req_t  pending_q[$];
  frame_rsp_t  expected_q[$];
  int unsigned n_errors      = 0;
  int unsigned n_accepted    = 0;
  bit          req_fire      = 1'b0;
  bit          rsp_fire      = 1'b0;
  bit          idle_on       = 1'b1;
  int unsigned req_gap       = 0;
  int unsigned rsp_stall     = 0;
  int unsigned hold_request  = 0;
  int unsigned hold_left     = 0;

  initial begin
    for (int w = 0; w < N_WORDS; w++) frame_words[w] = '1;
  end

  function automatic int unsigned frames_total();
    int unsigned n;
    n = mem_kb / 4;
    return (n > N_FRAMES) ? N_FRAMES : n;
  endfunction

  function automatic frame_rsp_t map_update(logic [OPCODE_W-1:0] opcode,
                                            logic [ADDR_IN_W-1:0] addr);
    frame_rsp_t  r;
    int unsigned total, lim, f, w, b;
    bit          found;
    r.result_address = '0;
    r.status         = STATUS_OK;
    total            = frames_total();
    found            = 1'b0;
    case (opcode)
      OP_ALLOC: begin
        r.status = STATUS_NO_MEM;
        for (w = 0; w < N_WORDS && !found && w * WORD_BITS < total; w++) begin
          if (frame_words[w] != '1) begin
            for (b = 0; b < WORD_BITS && !found; b++) begin
              f = w * WORD_BITS + b;
              if (f < total && !frame_words[w][b]) begin
                frame_words[w][b] = 1'b1;
                r.result_address  = ADDR_W'(f << FRAME_SHIFT);
                r.status          = STATUS_OK;
                found             = 1'b1;
              end
            end
          end
        end
      end
      OP_FREE: begin
        f = addr >> FRAME_SHIFT;
        if (f < total) begin
          frame_words[f / WORD_BITS][f % WORD_BITS] = 1'b0;
        end else begin
          r.status = STATUS_RANGE;
        end
      end
      OP_INIT: begin
        lim = (init_free < total) ? init_free : total;
        for (w = 0; w < N_WORDS; w++) frame_words[w] = '1;
        for (f = 0; f < lim; f++) frame_words[f / WORD_BITS][f % WORD_BITS] = 1'b0;
        frame_words[0][0] = 1'b1;
        if (rsv_lo <= rsv_hi) begin
          for (f = rsv_lo; f <= rsv_hi; f++) begin
            frame_words[f / WORD_BITS][f % WORD_BITS] = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void note_error(string msg);
    n_errors++;
    if (n_errors <= 10) $display("%0t ns: %s", $realtime, msg);
  endfunction

  // Request driver: presents the oldest pending item, after a random gap while gaps are enabled.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_fire) begin
        req_fire = 1'b0;
        req_gap  = idle_on ? $urandom_range(0, 5) : 0;
      end
      if (req_gap > 0) begin
        req_gap--;
        req_if.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        req_if.valid         <= 1'b1;
        req_if.opcode        <= pending_q[0].opcode;
        req_if.frame_address <= pending_q[0].frame_address;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response receiver: random stalls while they are enabled, plus one long hold-off.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_fire) begin
        rsp_fire  = 1'b0;
        rsp_stall = idle_on ? $urandom_range(0, 5) : 0;
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: checks responses first, then records newly accepted requests.
  always @(posedge clk_i) begin
    frame_rsp_t exp_rsp;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_fire = 1'b1;
        if (expected_q.size() == 0) begin
          note_error($sformatf("unexpected result: address %h status %0d",
                               rsp_if.result_address, rsp_if.status));
        end else begin
          exp_rsp = expected_q.pop_front();
          if (rsp_if.result_address !== exp_rsp.result_address) begin
            note_error($sformatf("result_address: expected %h, got %h",
                                 exp_rsp.result_address, rsp_if.result_address));
          end
          if (rsp_if.status !== exp_rsp.status) begin
            note_error($sformatf("status: expected %0d, got %0d",
                                 exp_rsp.status, rsp_if.status));
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        expected_q.push_back(map_update(req_if.opcode, req_if.frame_address));
        void'(pending_q.pop_front());
        req_fire = 1'b1;
        n_accepted++;
      end
    end
  end

  task automatic wait_drained();
    while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MEM_SIZE_KB: mem_kb    = data[MEM_KB_W-1:0];
      REG_INIT_FREE:   init_free = data[INIT_FREE_W-1:0];
      REG_RSV_FIRST:   rsv_lo    = data[RSV_W-1:0];
      REG_RSV_LAST:    rsv_hi    = data[RSV_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic apply_config(input int unsigned kb, input int unsigned free_n,
                              input int unsigned lo, input int unsigned hi);
    wait_drained();
    write_reg(REG_MEM_SIZE_KB, CFG_DATA_W'(kb));
    write_reg(REG_INIT_FREE, CFG_DATA_W'(free_n));
    write_reg(REG_RSV_FIRST, CFG_DATA_W'(lo));
    write_reg(REG_RSV_LAST, CFG_DATA_W'(hi));
    @(posedge clk_i);
  endtask

  task automatic push_item(input logic [OPCODE_W-1:0] opcode,
                           input logic [ADDR_IN_W-1:0] addr);
    frame_req_t item;
    item.opcode        = opcode;
    item.frame_address = addr;
    pending_q.push_back(item);
  endtask

  initial begin : stimulus
    int unsigned kb, total, free_n, lo, hi, pick, frame, hold_at;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = REG_MEM_SIZE_KB;
    cfg_data_i           = '0;
    req_if.valid         = 1'b0;
    req_if.opcode        = OP_NOP;
    req_if.frame_address = '0;
    rsp_if.ready         = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers at their reset values; alloc before any init finds nothing.
    push_item(OP_ALLOC, 32'h0);
    push_item(OP_NOP, 32'hFFFF_FFFF);
    push_item(OP_INIT, 32'h0);
    push_item(OP_ALLOC, 32'h0);
    push_item(OP_ALLOC, 32'h0);
    push_item(OP_FREE, 32'h0000_1FFF);
    push_item(OP_FREE, 32'h0000_1000);
    push_item(OP_FREE, 32'hFFFF_FFFF);
    push_item(OP_FREE, 32'h0800_0000);
    push_item(OP_FREE, 32'h07FF_F000);
    push_item(OP_ALLOC, 32'h0);
    push_item(OP_FREE, 32'h0);
    push_item(OP_ALLOC, 32'h0);

    // Oversized memory, nothing freed, last frame reserved.
    apply_config(18'h3FFFF, 0, 32767, 32767);
    push_item(OP_INIT, 32'h0);
    push_item(OP_ALLOC, 32'h0);
    push_item(OP_FREE, 32'h07FF_F000);
    push_item(OP_ALLOC, 32'h0);

    // No memory at all, empty reserved range.
    apply_config(0, 16'hFFFF, 10, 3);
    push_item(OP_INIT, 32'h0);
    push_item(OP_ALLOC, 32'h0);
    push_item(OP_FREE, 32'h0);

    // Forty frames, initial free count far beyond the total.
    apply_config(163, 16'hFFFF, 2, 3);
    push_item(OP_INIT, 32'h0);
    push_item(OP_ALLOC, 32'h0);
    push_item(OP_ALLOC, 32'h0);
    apply_config(163, 16'hFFFF, 3, 2);
    push_item(OP_INIT, 32'h0);
    push_item(OP_ALLOC, 32'h0);
    push_item(OP_ALLOC, 32'h0);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      kb    = (ph == 0) ? MEM_KB_RESET : $urandom_range(0, 2100);
      total = (kb / 4 > N_FRAMES) ? N_FRAMES : kb / 4;
      case ($urandom_range(0, 3))
        0:       free_n = $urandom_range(0, total);
        1:       free_n = 16'hFFFF;
        2:       free_n = $urandom_range(0, 16'hFFFF);
        default: free_n = total;
      endcase
      lo = $urandom_range(0, total + 4);
      case ($urandom_range(0, 3))
        0:       hi = lo;
        1:       hi = lo + $urandom_range(0, 12);
        2:       hi = $urandom_range(0, lo);
        default: hi = $urandom_range(0, 32767);
      endcase
      if (ph == 5) begin
        lo = 0;
        hi = 32767;
      end
      apply_config(kb, free_n, lo & 32'h7FFF, hi & 32'h7FFF);
      idle_on = (ph % 4 != 2);

      push_item(OP_INIT, $urandom);
      for (int i = 1; i < PHASE_LEN; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          push_item(OP_INIT, $urandom);
        end else if (pick < 6) begin
          push_item(OP_NOP, $urandom);
        end else if (pick < 52) begin
          push_item(OP_ALLOC, $urandom);
        end else if (pick < 88) begin
          frame = $urandom_range(0, total + total / 8 + 2);
          push_item(OP_FREE, (frame << FRAME_SHIFT) | $urandom_range(0, 4095));
        end else begin
          push_item(OP_FREE, $urandom);
        end
      end

      // Hold the response side off long enough for the request side to back up.
      if (ph == 3) begin
        hold_at = n_accepted + 8;
        while (n_accepted < hold_at) @(posedge clk_i);
        hold_request = 400;
      end
    end

    wait_drained();
    repeat (1100) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
